// ----- hw/rtl/mlfq_pkg.sv -----
// mlfq_pkg: shared types and constants of the multilevel feedback scheduler
// no dependencies; used by the channel interfaces and every rtl module
`timescale 1ns / 1ps

package mlfq_pkg;

   localparam int ID_W    = 8;
   localparam int PRIO_W  = 8;
   localparam int BURST_W = 16;
   localparam int STAMP_W = 32;
   localparam int OUT_LEVEL_W = 2;

   // request kinds
   localparam logic MODE_TICK    = 1'b0;
   localparam logic MODE_ARRIVAL = 1'b1;

   // one request as it travels from front to back
   typedef struct packed {
      logic               mode;
      logic [ID_W-1:0]    process_id;
      logic [PRIO_W-1:0]  priority_req;
      logic [BURST_W-1:0] burst_ticks;
   } cmd_type;

   // handshake between the request queue and the scheduler engine
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

endpackage

// ----- hw/rtl/mlfq_if.sv -----
// mlfq_req_if and mlfq_rsp_if: valid/ready channels of the scheduler
// depends on mlfq_pkg for the field widths
`timescale 1ns / 1ps

interface mlfq_req_if import mlfq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               mode;
   logic [ID_W-1:0]    process_id;
   logic [PRIO_W-1:0]  priority_req;
   logic [BURST_W-1:0] burst_ticks;

   modport source (output valid, mode, process_id, priority_req, burst_ticks,
                   input ready);
   modport sink (input valid, mode, process_id, priority_req, burst_ticks,
                 output ready);
endinterface

interface mlfq_rsp_if import mlfq_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   running_valid;
   logic [ID_W-1:0]        running_id;
   logic [OUT_LEVEL_W-1:0] running_level;
   logic                   dropped;

   modport source (output valid, running_valid, running_id, running_level,
                   dropped, input ready);
   modport sink (input valid, running_valid, running_id, running_level,
                 dropped, output ready);
endinterface

// ----- hw/rtl/mlfq_front.sv -----
// mlfq_front: accepts requests, classifies them and holds them in a
// two-entry queue for the engine; depends on mlfq_pkg and mlfq_req_if
`timescale 1ns / 1ps

module mlfq_front import mlfq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mlfq_req_if.sink   req_chan,
   output cmd_chan_type cmd_out,
   input  logic       cmd_ready
);

   cmd_type    q_data_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   cmd_type    cmd_new;

   // classify the incoming request
   always_comb begin
      cmd_new.mode         = req_chan.mode;
      cmd_new.process_id   = req_chan.process_id;
      cmd_new.priority_req = req_chan.priority_req;
      cmd_new.burst_ticks  = req_chan.burst_ticks;
   end

   assign req_chan.ready = (count_ff != 2'd2);
   assign push = req_chan.valid && req_chan.ready;
   assign pop  = cmd_out.valid && cmd_ready;

   assign cmd_out.valid = (count_ff != 2'd0);
   assign cmd_out.cmd   = q_data_ff[rd_ptr_ff];

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_data_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ----- hw/rtl/mlfq_back.sv -----
// mlfq_back: scheduler engine with the slot table, sequential scans for
// free slots and picks, and the result register; depends on mlfq_pkg
`timescale 1ns / 1ps

module mlfq_back import mlfq_pkg::*; #(
   parameter int NUM_SLOTS  = 16,
   parameter int NUM_LEVELS = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_chan_type cmd_in,
   output logic         cmd_ready,
   mlfq_rsp_if.source   rsp_chan
);

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int TW = NUM_LEVELS;
   localparam logic [LW-1:0] TOP_LEVEL = LW'(NUM_LEVELS - 1);
   localparam logic [CW-1:0] SLOT_COUNT = CW'(NUM_SLOTS);
   localparam logic [CW-1:0] LAST_SLOT = CW'(NUM_SLOTS - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ARR  = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_PEND = 3'd3;
   localparam logic [2:0] S_LOAD = 3'd4;
   localparam logic [2:0] S_RUN  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   // slot table memory
   logic [LW-1:0]      mem_level [NUM_SLOTS];
   logic [PRIO_W-1:0]  mem_prio  [NUM_SLOTS];
   logic [BURST_W-1:0] mem_rem   [NUM_SLOTS];
   logic [ID_W-1:0]    mem_ident [NUM_SLOTS];
   logic [STAMP_W-1:0] mem_stamp [NUM_SLOTS];

   logic [LW-1:0]      rd_level_ff;
   logic [PRIO_W-1:0]  rd_prio_ff;
   logic [BURST_W-1:0] rd_rem_ff;
   logic [ID_W-1:0]    rd_ident_ff;
   logic [STAMP_W-1:0] rd_stamp_ff;

   logic [SW-1:0]      rd_addr, wr_addr;
   logic               we_all, we_pick, we_rem;
   logic [LW-1:0]      wd_level;
   logic [BURST_W-1:0] wd_rem;

   // control state
   logic [2:0]          state_ff, state_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [STAMP_W-1:0]  stamp_ctr_ff, stamp_ctr_in;
   logic                run_active_ff, run_active_in;
   logic [SW-1:0]       run_slot_ff, run_slot_in;
   logic [LW-1:0]       run_level_ff, run_level_in;
   logic [TW-1:0]       run_ticks_ff, run_ticks_in;
   logic [BURST_W-1:0]  run_rem_ff, run_rem_in;
   logic [ID_W-1:0]     run_ident_ff, run_ident_in;
   cmd_type             cur_ff, cur_in;
   logic                drop_ff, drop_in;

   // scan registers
   logic [CW-1:0]       scan_idx_ff, scan_idx_in;
   logic                pend_ff, pend_in;
   logic [SW-1:0]       pend_idx_ff, pend_idx_in;
   logic                found_ff, found_in;
   logic [SW-1:0]       best_slot_ff, best_slot_in;
   logic [LW-1:0]       best_level_ff, best_level_in;
   logic [PRIO_W-1:0]   best_prio_ff, best_prio_in;
   logic [STAMP_W-1:0]  best_age_ff, best_age_in;

   // result register
   logic                out_valid_ff, out_valid_in;
   logic                out_run_ff, out_run_in;
   logic [ID_W-1:0]     out_id_ff, out_id_in;
   logic [OUT_LEVEL_W-1:0] out_level_ff, out_level_in;
   logic                out_drop_ff, out_drop_in;

   logic [STAMP_W-1:0]  cand_age;
   logic                cand_better;
   logic [TW-1:0]       quantum;
   logic                out_free;

   assign cmd_ready = (state_ff == S_IDLE);
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign quantum   = TW'(1) << run_level_ff;

   // compare the entry read last cycle with the best so far
   assign cand_age = stamp_ctr_ff - rd_stamp_ff;
   always_comb begin
      cand_better = 1'b0;
      if (pend_ff && valid_ff[pend_idx_ff]) begin
         if (!found_ff || rd_level_ff < best_level_ff) begin
            cand_better = 1'b1;
         end else if (rd_level_ff == best_level_ff) begin
            if (rd_prio_ff > best_prio_ff) begin
               cand_better = 1'b1;
            end else if (rd_prio_ff == best_prio_ff && cand_age < best_age_ff) begin
               cand_better = 1'b1;
            end
         end
      end
   end

   // engine sequencer
   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      stamp_ctr_in  = stamp_ctr_ff;
      run_active_in = run_active_ff;
      run_slot_in   = run_slot_ff;
      run_level_in  = run_level_ff;
      run_ticks_in  = run_ticks_ff;
      run_rem_in    = run_rem_ff;
      run_ident_in  = run_ident_ff;
      cur_in        = cur_ff;
      drop_in       = drop_ff;
      scan_idx_in   = scan_idx_ff;
      pend_in       = 1'b0;
      pend_idx_in   = scan_idx_ff[SW-1:0];
      found_in      = found_ff;
      best_slot_in  = best_slot_ff;
      best_level_in = best_level_ff;
      best_prio_in  = best_prio_ff;
      best_age_in   = best_age_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_run_in    = out_run_ff;
      out_id_in     = out_id_ff;
      out_level_in  = out_level_ff;
      out_drop_in   = out_drop_ff;
      rd_addr       = scan_idx_ff[SW-1:0];
      wr_addr       = scan_idx_ff[SW-1:0];
      we_all        = 1'b0;
      we_pick       = 1'b0;
      we_rem        = 1'b0;
      wd_level      = '0;
      wd_rem        = cur_ff.burst_ticks;

      case (state_ff)
         S_IDLE: begin
            scan_idx_in = '0;
            found_in    = 1'b0;
            drop_in     = 1'b0;
            if (cmd_in.valid) begin
               cur_in = cmd_in.cmd;
               if (cmd_in.cmd.mode == MODE_ARRIVAL) begin
                  state_in = S_ARR;
               end else if (!run_active_ff) begin
                  state_in = S_SCAN;
               end else if (run_ticks_ff == quantum && run_rem_ff != '0 &&
                            run_level_ff != TOP_LEVEL) begin
                  state_in = S_SCAN;
               end else if (run_rem_ff == '0) begin
                  valid_in[run_slot_ff] = 1'b0;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_RUN;
               end
            end
         end

         // look for the lowest free slot, one per cycle
         S_ARR: begin
            if (!valid_ff[scan_idx_ff[SW-1:0]]) begin
               we_all = 1'b1;
               valid_in[scan_idx_ff[SW-1:0]] = 1'b1;
               stamp_ctr_in = stamp_ctr_ff + STAMP_W'(1);
               state_in = S_OUT;
            end else if (scan_idx_ff == LAST_SLOT) begin
               drop_in  = 1'b1;
               state_in = S_OUT;
            end else begin
               scan_idx_in = scan_idx_ff + CW'(1);
            end
         end

         // read one slot per cycle and keep the best candidate
         S_SCAN: begin
            if (scan_idx_ff < SLOT_COUNT) begin
               pend_in     = 1'b1;
               scan_idx_in = scan_idx_ff + CW'(1);
            end else if (!pend_ff) begin
               state_in = S_PEND;
            end
            if (cand_better) begin
               found_in      = 1'b1;
               best_slot_in  = pend_idx_ff;
               best_level_in = rd_level_ff;
               best_prio_in  = rd_prio_ff;
               best_age_in   = cand_age;
            end
         end

         // commit the pick: demote it unless it is at the top level, and start reading its work
         S_PEND: begin
            rd_addr = best_slot_ff;
            wr_addr = best_slot_ff;
            run_active_in = found_ff;
            if (found_ff) begin
               run_slot_in  = best_slot_ff;
               run_level_in = best_level_ff;
               run_ticks_in = '0;
               if (best_level_ff != TOP_LEVEL) begin
                  we_pick      = 1'b1;
                  wd_level     = best_level_ff + LW'(1);
                  stamp_ctr_in = stamp_ctr_ff + STAMP_W'(1);
               end
               state_in = S_LOAD;
            end else begin
               state_in = S_OUT;
            end
         end

         S_LOAD: begin
            run_rem_in   = rd_rem_ff;
            run_ident_in = rd_ident_ff;
            state_in     = S_RUN;
         end

         // one tick of work on the running process
         S_RUN: begin
            wr_addr = run_slot_ff;
            if (run_rem_ff != '0) begin
               run_rem_in = run_rem_ff - BURST_W'(1);
               we_rem     = 1'b1;
               wd_rem     = run_rem_ff - BURST_W'(1);
            end
            if (run_ticks_ff != '1) begin
               run_ticks_in = run_ticks_ff + TW'(1);
            end
            state_in = S_OUT;
         end

         S_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_run_in   = run_active_ff;
               out_id_in    = run_active_ff ? run_ident_ff : '0;
               out_level_in = run_active_ff ? OUT_LEVEL_W'(run_level_ff) : '0;
               out_drop_in  = drop_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         stamp_ctr_ff  <= '0;
         run_active_ff <= 1'b0;
         run_slot_ff   <= '0;
         run_level_ff  <= '0;
         run_ticks_ff  <= '0;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         stamp_ctr_ff  <= stamp_ctr_in;
         run_active_ff <= run_active_in;
         run_slot_ff   <= run_slot_in;
         run_level_ff  <= run_level_in;
         run_ticks_ff  <= run_ticks_in;
         pend_ff       <= pend_in;
         found_ff      <= found_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      run_rem_ff    <= run_rem_in;
      run_ident_ff  <= run_ident_in;
      cur_ff        <= cur_in;
      drop_ff       <= drop_in;
      scan_idx_ff   <= scan_idx_in;
      pend_idx_ff   <= pend_idx_in;
      best_slot_ff  <= best_slot_in;
      best_level_ff <= best_level_in;
      best_prio_ff  <= best_prio_in;
      best_age_ff   <= best_age_in;
      out_run_ff    <= out_run_in;
      out_id_ff     <= out_id_in;
      out_level_ff  <= out_level_in;
      out_drop_ff   <= out_drop_in;
   end

   // slot table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we_all) begin
         mem_level[wr_addr] <= '0;
         mem_prio[wr_addr]  <= cur_ff.priority_req;
         mem_rem[wr_addr]   <= wd_rem;
         mem_ident[wr_addr] <= cur_ff.process_id;
         mem_stamp[wr_addr] <= stamp_ctr_ff;
      end
      if (we_pick) begin
         mem_level[wr_addr] <= wd_level;
         mem_stamp[wr_addr] <= stamp_ctr_ff;
      end
      if (we_rem) begin
         mem_rem[wr_addr] <= wd_rem;
      end
      rd_level_ff <= mem_level[rd_addr];
      rd_prio_ff  <= mem_prio[rd_addr];
      rd_rem_ff   <= mem_rem[rd_addr];
      rd_ident_ff <= mem_ident[rd_addr];
      rd_stamp_ff <= mem_stamp[rd_addr];
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.running_valid = out_run_ff;
   assign rsp_chan.running_id    = out_id_ff;
   assign rsp_chan.running_level = out_level_ff;
   assign rsp_chan.dropped       = out_drop_ff;

endmodule

// ----- hw/rtl/multilevel_feedback_scheduler_core.sv -----
// Multilevel feedback scheduler over NUM_SLOTS process slots and NUM_LEVELS
// levels. Each request (a tick or an arrival) yields exactly one response in
// order. A front queue of two requests lets the sender run ahead while the
// engine works. An arrival searches for a free slot, one slot per cycle; a
// tick that keeps the current process needs no scan, and a tick that picks
// runs the pick scan, which reads one table entry per cycle through the
// single read port of the slot table.
// No clearing pass follows reset.
// Depends on mlfq_pkg, the channel interfaces, mlfq_front and mlfq_back.
`timescale 1ns / 1ps

module multilevel_feedback_scheduler_core import mlfq_pkg::*; #(
   parameter int NUM_SLOTS  = 16,
   parameter int NUM_LEVELS = 4
) (
   input  logic       clock,
   input  logic       reset,
   mlfq_req_if.sink   req_chan,
   mlfq_rsp_if.source rsp_chan
);

   cmd_chan_type cmd_chan;
   logic         cmd_ready;

   // request intake and queue
   mlfq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_out   (cmd_chan),
      .cmd_ready (cmd_ready)
   );

   // scheduling engine
   mlfq_back #(
      .NUM_SLOTS  (NUM_SLOTS),
      .NUM_LEVELS (NUM_LEVELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_in    (cmd_chan),
      .cmd_ready (cmd_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- hw/rtl/mlfq_checker.sv -----
// mlfq_checker: port-level assertions for the scheduler core
// depends on mlfq_pkg; bound to multilevel_feedback_scheduler_core below
`timescale 1ns / 1ps

module mlfq_checker import mlfq_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   running_valid,
   input logic [ID_W-1:0]        running_id,
   input logic [OUT_LEVEL_W-1:0] running_level,
   input logic                   dropped
);

   logic [3:0] outstanding_ff;
   logic [3:0] outstanding_in;

   // requests taken but not yet answered
   assign outstanding_in = outstanding_ff + 4'(req_valid && req_ready)
                           - 4'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // no response without a request behind it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 4'd0)
      else $error("response without outstanding request");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(running_id) &&
      $stable(dropped) && $stable(running_valid))
      else $error("stalled response changed");

   // idle report carries zero id and level
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !running_valid |-> running_id == '0 && running_level == '0)
      else $error("idle response with nonzero fields");

endmodule

bind multilevel_feedback_scheduler_core mlfq_checker u_mlfq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .running_valid (rsp_chan.running_valid),
   .running_id    (rsp_chan.running_id),
   .running_level (rsp_chan.running_level),
   .dropped       (rsp_chan.dropped)
);
